[rtl/arpc_pkg.sv]
package arpc_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int OPC_W       = 16;
    localparam int PREFIX_W    = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 6'd24;

    // ARP operation codes.
    localparam logic [OPC_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OPC_W-1:0] OP_REPLY   = 16'd2;

    // Input modes.
    localparam logic MODE_PACKET  = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    // Result actions.
    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_REPLY    = 2'd1,
        ACT_REQUEST  = 2'd2,
        ACT_RESOLVED = 2'd3
    } t_action;

    // Controller states.
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MATCH = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic finish;
    } t_cmd;

    // Subnet mask with prefix leading ones; a prefix of 32 or more gives all ones.
    function automatic logic [IP_W-1:0] subnet_mask(input logic [PREFIX_W-1:0] prefix);
        logic [IP_W-1:0] ones;
        ones = '1;
        return ~(ones >> prefix);
    endfunction

endpackage

[rtl/arpc_ctrl.sv]
module arpc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output arpc_pkg::t_cmd o_cmd
);

    arpc_pkg::t_state r_state;
    arpc_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             slot_free;

    // The output register can take a new result when empty or draining now.
    assign slot_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            arpc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = arpc_pkg::ST_MATCH;
                end
            end
            arpc_pkg::ST_MATCH: begin
                if (slot_free) begin
                    n_state = arpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands.
    always_comb begin
        o_cmd.load   = 1'b0;
        o_cmd.finish = 1'b0;
        o_in_stall   = 1'b1;
        case (r_state)
            arpc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            arpc_pkg::ST_MATCH: begin
                o_cmd.finish = slot_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Output valid flag: set when a result is written, cleared on its transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/arpc_dpath.sv]
module arpc_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  arpc_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_mode,
    input  logic [arpc_pkg::OPC_W-1:0]          i_opcode,
    input  logic [arpc_pkg::IP_W-1:0]           i_target_ip,
    input  logic [arpc_pkg::IP_W-1:0]           i_sender_ip,
    input  logic [arpc_pkg::MAC_W-1:0]          i_sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]           i_lookup_ip,
    output logic [1:0]                          o_action,
    output logic [arpc_pkg::MAC_W-1:0]          o_peer_mac,
    output logic [arpc_pkg::IP_W-1:0]           o_peer_ip
);

    localparam int DEPTH = arpc_pkg::TABLE_DEPTH;

    // Configuration registers.
    logic [arpc_pkg::IP_W-1:0]     r_own_ip;
    logic [arpc_pkg::PREFIX_W-1:0] r_prefix_len;
    logic [arpc_pkg::IP_W-1:0]     r_gateway_ip;

    // Captured item.
    logic                          r_mode;
    logic                          r_learn;
    logic                          r_is_req;
    logic [arpc_pkg::IP_W-1:0]     r_key;
    logic [arpc_pkg::MAC_W-1:0]    r_mac;

    // Cache table, index 0 is the oldest entry.
    logic [arpc_pkg::IP_W-1:0]     r_entry_ip  [DEPTH];
    logic [arpc_pkg::MAC_W-1:0]    r_entry_mac [DEPTH];
    logic [DEPTH-1:0]              r_entry_valid;

    // Result register.
    arpc_pkg::t_action             r_action;
    logic [arpc_pkg::MAC_W-1:0]    r_peer_mac;
    logic [arpc_pkg::IP_W-1:0]     r_peer_ip;

    logic [arpc_pkg::IP_W-1:0]     mask;
    logic [arpc_pkg::IP_W-1:0]     hop;
    logic                          for_us;
    logic [DEPTH-1:0]              hit_vec;
    logic                          hit;
    logic [arpc_pkg::IDX_W-1:0]    hit_idx;
    logic                          do_shift;
    arpc_pkg::t_action             n_action;
    logic [arpc_pkg::MAC_W-1:0]    n_peer_mac;
    logic [arpc_pkg::IP_W-1:0]     n_peer_ip;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip     <= '0;
            r_prefix_len <= arpc_pkg::PREFIX_RESET;
            r_gateway_ip <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arpc_pkg::CFG_OWN_IP:     r_own_ip     <= i_cfg_data;
                arpc_pkg::CFG_PREFIX_LEN: r_prefix_len <= i_cfg_data[arpc_pkg::PREFIX_W-1:0];
                arpc_pkg::CFG_GATEWAY_IP: r_gateway_ip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next hop selection and packet qualification on the incoming item.
    assign mask   = arpc_pkg::subnet_mask(r_prefix_len);
    assign hop    = ((i_lookup_ip & mask) != (r_own_ip & mask)) ? r_gateway_ip : i_lookup_ip;
    assign for_us = (i_target_ip == r_own_ip)
                    && (i_opcode == arpc_pkg::OP_REQUEST || i_opcode == arpc_pkg::OP_REPLY);

    // Capture the item; the key is the sender IP for packets and the next hop otherwise.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_learn  <= for_us;
            r_is_req <= (i_opcode == arpc_pkg::OP_REQUEST);
            r_key    <= (i_mode == arpc_pkg::MODE_RESOLVE) ? hop : i_sender_ip;
            r_mac    <= i_sender_mac;
        end
    end

    // Compare the key against every valid entry in parallel.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit_vec[i] = r_entry_valid[i] && (r_entry_ip[i] == r_key);
        end
    end

    // Lowest matching index wins.
    always_comb begin
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = arpc_pkg::IDX_W'(i);
            end
        end
    end

    assign hit = |hit_vec;

    // Result and learning decision.
    always_comb begin
        n_action   = arpc_pkg::ACT_NONE;
        n_peer_mac = '0;
        n_peer_ip  = '0;
        do_shift   = 1'b0;
        if (r_mode == arpc_pkg::MODE_PACKET) begin
            if (r_learn) begin
                do_shift = !hit;
                if (r_is_req) begin
                    n_action   = arpc_pkg::ACT_REPLY;
                    n_peer_mac = r_mac;
                    n_peer_ip  = r_key;
                end
            end
        end else begin
            n_peer_ip = r_key;
            if (hit) begin
                n_action   = arpc_pkg::ACT_RESOLVED;
                n_peer_mac = r_entry_mac[hit_idx];
            end else begin
                n_action   = arpc_pkg::ACT_REQUEST;
            end
        end
    end

    // Table update: shift toward index 0 and append the new pair at the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (i_cmd.finish && do_shift) begin
            r_entry_valid <= {1'b1, r_entry_valid[DEPTH-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && do_shift) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_entry_ip[i]  <= r_entry_ip[i+1];
                r_entry_mac[i] <= r_entry_mac[i+1];
            end
            r_entry_ip[DEPTH-1]  <= r_key;
            r_entry_mac[DEPTH-1] <= r_mac;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_action   <= n_action;
            r_peer_mac <= n_peer_mac;
            r_peer_ip  <= n_peer_ip;
        end
    end

    assign o_action   = r_action;
    assign o_peer_mac = r_peer_mac;
    assign o_peer_ip  = r_peer_ip;

endmodule

[rtl/arp_cache_resolver_top.sv]
// ARP cache resolver. An item is either a parsed ARP packet (mode 0), which
// may teach the eight-entry cache its sender pair and ask for a reply, or a
// resolve request (mode 1), which maps an address, or the gateway for an
// off-subnet address, to a cached MAC or asks for an ARP request. Each item
// gives exactly one result. Its capture step registers it and selects the
// next hop; its finish step compares all cache entries in parallel and
// updates the table shift and result register, and waits while the output
// register still holds an untaken result. The input is stalled until the
// item is finished. The cache is empty after reset; new pairs enter at the
// top and the oldest entry is dropped.
module arp_cache_resolver_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [arpc_pkg::OPC_W-1:0]      i_opcode,
    input  logic [arpc_pkg::IP_W-1:0]       i_target_ip,
    input  logic [arpc_pkg::IP_W-1:0]       i_sender_ip,
    input  logic [arpc_pkg::MAC_W-1:0]      i_sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]       i_lookup_ip,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_action,
    output logic [arpc_pkg::MAC_W-1:0]      o_peer_mac,
    output logic [arpc_pkg::IP_W-1:0]       o_peer_ip
);

    arpc_pkg::t_cmd cmd;

    // Sequencing of capture and finish.
    arpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Configuration, cache table and result register.
    arpc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_opcode     (i_opcode),
        .i_target_ip  (i_target_ip),
        .i_sender_ip  (i_sender_ip),
        .i_sender_mac (i_sender_mac),
        .i_lookup_ip  (i_lookup_ip),
        .o_action     (o_action),
        .o_peer_mac   (o_peer_mac),
        .o_peer_ip    (o_peer_ip)
    );

    // An accepted item holds off the next one right after its transfer.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // A new result only appears while an item is being worked on.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in progress");

    // A result with no action carries no addresses.
    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == arpc_pkg::ACT_NONE |-> o_peer_mac == '0 && o_peer_ip == '0)
        else $error("empty action with nonzero addresses");

    // A request for resolution carries no MAC.
    a_request_no_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action == arpc_pkg::ACT_REQUEST |-> o_peer_mac == '0)
        else $error("ARP request action with a MAC");

endmodule

[verif/tb_arp_cache_resolver_top.sv]
`timescale 1ns / 1ps

module tb_arp_cache_resolver_top;

    import arpc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE   = 12;
    localparam int PHASE_ITEMS = 210;

    // Fields of one input transfer.
    typedef struct {
        logic             mode;
        logic [OPC_W-1:0] opcode;
        logic [IP_W-1:0]  target_ip;
        logic [IP_W-1:0]  sender_ip;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  lookup_ip;
    } arp_item_t;

    // Fields of one output transfer.
    typedef struct {
        logic [1:0]       action;
        logic [MAC_W-1:0] peer_mac;
        logic [IP_W-1:0]  peer_ip;
    } arp_answer_t;

    // Shadow copy of the cache and its registers. Every accepted input transfer
    // is played against it, and the answer it predicts waits in a queue until
    // the block delivers its own.
    class arp_cache_shadow;
        logic [IP_W-1:0]     own_ip;
        logic [PREFIX_W-1:0] prefix_len;
        logic [IP_W-1:0]     gateway_ip;
        logic [IP_W-1:0]     slot_ip[TABLE_DEPTH];
        logic [MAC_W-1:0]    slot_mac[TABLE_DEPTH];
        bit                  slot_used[TABLE_DEPTH];
        arp_answer_t         due_answers[$];
        int                  errors;

        function new();
            own_ip     = '0;
            prefix_len = PREFIX_RESET;
            gateway_ip = '0;
            errors     = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_ip[i]   = '0;
                slot_mac[i]  = '0;
                slot_used[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OWN_IP:     own_ip     = data[IP_W-1:0];
                CFG_PREFIX_LEN: prefix_len = data[PREFIX_W-1:0];
                CFG_GATEWAY_IP: gateway_ip = data[IP_W-1:0];
                default: ;
            endcase
        endfunction

        // Ones shifted up by the host width; a shift of 32 leaves nothing, which
        // covers a zero prefix, and anything from 32 up keeps every bit.
        function logic [IP_W-1:0] net_mask();
            logic [IP_W-1:0] ones;
            ones = '1;
            if (prefix_len >= 32)
                return ones;
            return ones << (32 - prefix_len);
        endfunction

        // Lowest used slot holding the address, or -1.
        function int find_slot(logic [IP_W-1:0] ip);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_used[i] && slot_ip[i] == ip)
                    return i;
            end
            return -1;
        endfunction

        function void note_item(arp_item_t it);
            arp_answer_t     ans;
            logic [IP_W-1:0] mask;
            logic [IP_W-1:0] hop;
            int              hit;
            ans.action   = ACT_NONE;
            ans.peer_mac = '0;
            ans.peer_ip  = '0;
            if (it.mode == MODE_PACKET) begin
                if (it.target_ip == own_ip &&
                    (it.opcode == OP_REQUEST || it.opcode == OP_REPLY)) begin
                    // A new sender shifts every pair down and drops the oldest one.
                    if (find_slot(it.sender_ip) < 0) begin
                        for (int i = 1; i < TABLE_DEPTH; i++) begin
                            slot_ip[i-1]   = slot_ip[i];
                            slot_mac[i-1]  = slot_mac[i];
                            slot_used[i-1] = slot_used[i];
                        end
                        slot_ip[TABLE_DEPTH-1]   = it.sender_ip;
                        slot_mac[TABLE_DEPTH-1]  = it.sender_mac;
                        slot_used[TABLE_DEPTH-1] = 1'b1;
                    end
                    if (it.opcode == OP_REQUEST) begin
                        ans.action   = ACT_REPLY;
                        ans.peer_mac = it.sender_mac;
                        ans.peer_ip  = it.sender_ip;
                    end
                end
            end else begin
                // Off-subnet addresses are sent through the gateway.
                mask = net_mask();
                hop  = ((it.lookup_ip & mask) == (own_ip & mask)) ? it.lookup_ip : gateway_ip;
                hit  = find_slot(hop);
                ans.peer_ip = hop;
                if (hit < 0) begin
                    ans.action = ACT_REQUEST;
                end else begin
                    ans.action   = ACT_RESOLVED;
                    ans.peer_mac = slot_mac[hit];
                end
            end
            due_answers.push_back(ans);
        endfunction

        function void check_result(arp_answer_t got);
            arp_answer_t want;
            if (due_answers.size() == 0) begin
                $error("unexpected result: action %0d, peer_mac %h, peer_ip %h",
                       got.action, got.peer_mac, got.peer_ip);
                errors++;
                return;
            end
            want = due_answers.pop_front();
            if (got.action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                errors++;
            end
            if (got.peer_mac !== want.peer_mac) begin
                $error("peer_mac: expected %h, got %h", want.peer_mac, got.peer_mac);
                errors++;
            end
            if (got.peer_ip !== want.peer_ip) begin
                $error("peer_ip: expected %h, got %h", want.peer_ip, got.peer_ip);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_mode;
    logic [OPC_W-1:0]      i_opcode;
    logic [IP_W-1:0]       i_target_ip;
    logic [IP_W-1:0]       i_sender_ip;
    logic [MAC_W-1:0]      i_sender_mac;
    logic [IP_W-1:0]       i_lookup_ip;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_action;
    logic [MAC_W-1:0]      o_peer_mac;
    logic [IP_W-1:0]       o_peer_ip;

    arp_cache_shadow shadow;
    logic [IP_W-1:0] ip_pool[POOL_SIZE];
    int              idle_pct  = 0;
    int              stall_pct = 0;
    int              cycle_count = 0;

    arp_cache_resolver_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_opcode     (i_opcode),
        .i_target_ip  (i_target_ip),
        .i_sender_ip  (i_sender_ip),
        .i_sender_mac (i_sender_mac),
        .i_lookup_ip  (i_lookup_ip),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_action     (o_action),
        .o_peer_mac   (o_peer_mac),
        .o_peer_ip    (o_peer_ip)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_arp_cache_resolver_top: errors");
            $finish;
        end
    end

    // Result side: check each accepted transfer, then pick the next stall.
    always @(posedge i_clk) begin
        arp_answer_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.action   = o_action;
            got.peer_mac = o_peer_mac;
            got.peer_ip  = o_peer_ip;
            shadow.check_result(got);
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [MAC_W-1:0] any_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    function automatic arp_item_t arp_packet(logic [OPC_W-1:0] op, logic [IP_W-1:0] tip,
                                             logic [IP_W-1:0] sip, logic [MAC_W-1:0] mac);
        arp_item_t it;
        it.mode       = MODE_PACKET;
        it.opcode     = op;
        it.target_ip  = tip;
        it.sender_ip  = sip;
        it.sender_mac = mac;
        it.lookup_ip  = $urandom;
        return it;
    endfunction

    // Packet fields carry junk on a resolve; the block must ignore them.
    function automatic arp_item_t resolve_req(logic [IP_W-1:0] ip);
        arp_item_t it;
        it            = arp_packet(16'($urandom), $urandom, $urandom, any_mac());
        it.mode       = MODE_RESOLVE;
        it.lookup_ip  = ip;
        return it;
    endfunction

    // Addresses that recur, so that learning, hits and evictions all happen.
    function automatic void refill_pool();
        logic [IP_W-1:0] mask;
        mask = shadow.net_mask();
        for (int k = 0; k < POOL_SIZE; k++) begin
            if (k < 8)
                ip_pool[k] = (shadow.own_ip & mask) | ($urandom & ~mask);
            else
                ip_pool[k] = $urandom;
        end
        ip_pool[POOL_SIZE-1] = shadow.gateway_ip;
    endfunction

    function automatic logic [IP_W-1:0] pool_ip();
        return ip_pool[$urandom_range(POOL_SIZE-1)];
    endfunction

    // Mostly well-formed packets and lookups on the pool; the rest is noise.
    function automatic arp_item_t random_item(output bit useful);
        arp_item_t it;
        int        r;
        r = $urandom_range(99);
        if (r < 40) begin
            it = arp_packet(($urandom_range(1) != 0) ? OP_REQUEST : OP_REPLY,
                            ($urandom_range(9) == 0) ? $urandom : shadow.own_ip,
                            pool_ip(), any_mac());
            useful = (it.target_ip == shadow.own_ip);
        end else if (r < 75) begin
            it = resolve_req(($urandom_range(9) < 7) ? pool_ip() : $urandom);
            useful = 1'b1;
        end else begin
            it = arp_packet(($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(3)),
                            ($urandom_range(1) != 0) ? $urandom : shadow.own_ip,
                            ($urandom_range(1) != 0) ? $urandom : pool_ip(),
                            any_mac());
            it.mode = 1'($urandom_range(1));
            useful  = 1'b0;
        end
        return it;
    endfunction

    // Offer one transfer, with a random gap before it, and wait until it is taken.
    task automatic send_item(arp_item_t it);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= it.mode;
        i_opcode     <= it.opcode;
        i_target_ip  <= it.target_ip;
        i_sender_ip  <= it.sender_ip;
        i_sender_mac <= it.sender_mac;
        i_lookup_ip  <= it.lookup_ip;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        shadow.note_item(it);
    endtask

    // Stop offering and wait until every predicted answer has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (shadow.due_answers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg_port(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        shadow.write_reg(idx, data);
    endtask

    task automatic set_config(logic [IP_W-1:0] own, logic [CFG_DATA_W-1:0] prefix_word,
                              logic [IP_W-1:0] gw);
        write_reg_port(CFG_OWN_IP, own);
        write_reg_port(CFG_PREFIX_LEN, prefix_word);
        write_reg_port(CFG_GATEWAY_IP, gw);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        arp_item_t it;
        bit        useful;
        int        useful_count;
        shadow = new();
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_PACKET;
        i_opcode     <= '0;
        i_target_ip  <= '0;
        i_sender_ip  <= '0;
        i_sender_mac <= '0;
        i_lookup_ip  <= '0;
        i_out_stall  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct  = 14;
        stall_pct = 14;

        // Empty table after reset: 0.0.0.0 is an ordinary address and must miss.
        send_item(resolve_req(32'h0000_0000));
        send_item(arp_packet(OP_REQUEST, 32'h0000_0000, 32'h0000_0000, 48'hFFFF_FFFF_FFFF));
        send_item(resolve_req(32'h0000_00FF));
        send_item(resolve_req(32'h0000_0000));
        send_item(resolve_req(32'hFFFF_FFFF));
        drain();

        set_config(32'hC0A8_0101, 32'd24, 32'hC0A8_01FE);
        // Packets not for this station and unknown opcodes leave the table alone.
        send_item(arp_packet(OP_REQUEST, 32'hC0A8_0102, 32'hC0A8_0109, any_mac()));
        send_item(arp_packet(16'h0000, 32'hC0A8_0101, 32'hC0A8_0109, any_mac()));
        send_item(arp_packet(16'hFFFF, 32'hC0A8_0101, 32'hC0A8_0109, any_mac()));
        send_item(arp_packet(16'h0003, 32'hC0A8_0101, 32'hC0A8_0109, any_mac()));
        // A reply only learns, a request also answers, a known sender is not refreshed.
        send_item(arp_packet(OP_REPLY, 32'hC0A8_0101, 32'hC0A8_01FE, 48'h0));
        send_item(arp_packet(OP_REQUEST, 32'hC0A8_0101, 32'hC0A8_0105, 48'h0000_5E00_0105));
        send_item(arp_packet(OP_REQUEST, 32'hC0A8_0101, 32'hC0A8_0105, 48'hAAAA_5555_AAAA));
        send_item(resolve_req(32'hC0A8_0105));
        send_item(resolve_req(32'h0808_0808));
        send_item(resolve_req(32'hC0A8_0177));
        // Seven new senders push the two oldest pairs out, the gateway among them.
        for (int k = 0; k < 7; k++)
            send_item(arp_packet(OP_REPLY, 32'hC0A8_0101, 32'hC0A8_0110 + k, any_mac()));
        send_item(resolve_req(32'h0808_0808));
        drain();

        // A prefix above 32 behaves as 32.
        set_config(32'hFFFF_FFFF, 32'd63, 32'h0000_0000);
        send_item(resolve_req(32'hFFFF_FFFE));
        send_item(arp_packet(OP_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0));
        send_item(resolve_req(32'hFFFF_FFFF));
        drain();

        // A zero prefix puts every address on the own subnet.
        set_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_item(resolve_req(32'h1234_5678));
        send_item(resolve_req(32'hC0A8_0110));
        drain();

        // Random phases, each with its own registers and idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    set_config($urandom, ($urandom & ~32'h3F) | $urandom_range(31, 1),
                               $urandom);
                end
                1: begin
                    idle_pct  = 64;
                    stall_pct = 0;
                    set_config($urandom, $urandom & ~32'h3F, 32'hFFFF_FFFF);
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 64;
                    set_config($urandom, 32'd32, $urandom);
                end
                default: begin
                    idle_pct  = 14;
                    stall_pct = 14;
                    set_config(32'h0000_0000, ($urandom & ~32'h3F) | 32'd40, 32'h0000_0000);
                end
            endcase
            refill_pool();
            useful_count = 0;
            while (useful_count < PHASE_ITEMS) begin
                it = random_item(useful);
                send_item(it);
                if (useful)
                    useful_count++;
            end
            drain();
        end

        // Give a stray extra result time to show up.
        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.due_answers.size() == 0)
            $display("tb_arp_cache_resolver_top: clean");
        else
            $display("tb_arp_cache_resolver_top: errors");
        $finish;
    end

endmodule

[files.f]
rtl/arpc_pkg.sv
rtl/arpc_ctrl.sv
rtl/arpc_dpath.sv
rtl/arp_cache_resolver_top.sv
verif/tb_arp_cache_resolver_top.sv
